### src/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg: shared types and constants of the Simon block encryption core
// Register indexes, the five z bit sequences, the control state encoding and
// the control group that drives the serial key schedule.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int FIELD_W   = 32;
  localparam int KEY_WORDS = 4;
  localparam int ZLEN      = 62;
  localparam int ZSEQS     = 5;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY0        = 3'd0,
    CFG_KEY1        = 3'd1,
    CFG_KEY2        = 3'd2,
    CFG_KEY3        = 3'd3,
    CFG_KEY_COUNT   = 3'd4,
    CFG_ROUND_COUNT = 3'd5,
    CFG_Z_INDEX     = 3'd6
  } sbe_cfg_index_e;

  // z sequences, written first bit leftmost: bit n of a sequence is [ZLEN-1-n]
  localparam logic [ZLEN-1:0] Z_SEQ [ZSEQS] = '{
    62'b1111101000100101011000011100110_1111101000100101011000011100110,
    62'b1000111011111001001100001011010_1000111011111001001100001011010,
    62'b1010111101110000001101001001100_0101000010001111110010110110011,
    62'b1101101110101100011001011110000_0010010001010011100110100001111,
    62'b1101000111100110101101100010000_0010111000011001010010011101111
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } sbe_state_e;

  // Control from the round sequencer to the key schedule
  typedef struct packed {
    logic       load;      // take the configured key words
    logic       step;      // advance one bit
    logic       last_bit;  // final bit of a round
    logic       low_bit;   // bit 0 or 1 of the word
    logic [2:0] m;         // key word count, 2 to 4
    logic       z_bit;     // z bit, already gated to bit 0
  } sbe_ks_ctrl_t;

endpackage

### src/sbe_keysched.sv
// ----------------------------------------------------------------------------
// sbe_keysched: bit-serial Simon key schedule
// Holds a window of the last m round keys in shift registers. The current round
// key leaves bit by bit at the bottom of word 0 while the next key word is
// built into its top; at the end of a round the window advances by one word.
// ----------------------------------------------------------------------------
module sbe_keysched
  import sbe_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                               clk_i,
  input  sbe_ks_ctrl_t                       ctrl_i,
  input  logic [KEY_WORDS-1:0][FIELD_W-1:0]  key_words_i,
  output logic                               round_key_bit_o
);

  logic [KEY_WORDS-1:0][WORD_BITS-1:0] kw_q, kw_d, kw_rot;
  logic [WORD_BITS-1:0]                newest;
  logic [WORD_BITS-1:0]                fresh;
  logic                                tmp_bit;
  logic                                new_bit;

  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) begin
      kw_rot[i] = {kw_q[i][0], kw_q[i][WORD_BITS-1:1]};
    end

    priority if (ctrl_i.m == 3'd4) begin
      newest = kw_q[3];
    end else if (ctrl_i.m == 3'd3) begin
      newest = kw_q[2];
    end else begin
      newest = kw_q[1];
    end

    // rotr(k[i-1],3) ^ k[i-3] at bit j, and the same one bit higher
    tmp_bit = newest[3] ^ newest[4];
    if (ctrl_i.m == 3'd4) begin
      tmp_bit = tmp_bit ^ kw_q[1][0] ^ kw_q[1][1];
    end
    new_bit = kw_q[0][0] ^ ~ctrl_i.low_bit ^ ctrl_i.z_bit ^ tmp_bit;
    fresh   = {new_bit, kw_q[0][WORD_BITS-1:1]};

    kw_d = kw_q;
    if (ctrl_i.load) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        kw_d[i] = WORD_BITS'(key_words_i[i]);
      end
    end else if (ctrl_i.step) begin
      if (!ctrl_i.last_bit) begin
        kw_d[0] = fresh;
        kw_d[1] = kw_rot[1];
        kw_d[2] = kw_rot[2];
        kw_d[3] = kw_rot[3];
      end else begin
        // advance the window, the new word lands at slot m-1
        kw_d[0] = kw_rot[1];
        kw_d[1] = kw_rot[2];
        kw_d[2] = kw_rot[3];
        kw_d[3] = kw_rot[3];
        priority if (ctrl_i.m == 3'd2) begin
          kw_d[1] = fresh;
          kw_d[2] = kw_rot[2];
        end else if (ctrl_i.m == 3'd3) begin
          kw_d[2] = fresh;
        end else begin
          kw_d[3] = fresh;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kw_q <= kw_d;
  end

  assign round_key_bit_o = kw_q[0][0];

endmodule

### src/simon_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// simon_block_encrypt_core: bit-serial Simon block encryption (ECB)
// Encrypts one (x, y) block per request with round keys made on the fly.
//
// Usage:
//   s_axis carries a plaintext block, m_axis the ciphertext block; both move
//   on tvalid and tready high at a rising clock edge. The cfg channel writes
//   the key words, key word count, round count and z sequence index; it is
//   always ready. It must be written only while the core is idle; the core
//   itself does not enforce this. A round is computed one bit per cycle
//   through shift registers. A block runs T rounds (T the clamped round count)
//   after acceptance, and the next block is accepted only after the result is
//   moved into the output register, so no new block is taken while one is in progress.
//   The output register holds the result while m_axis_tready is low; a
//   finished block waits in the core until that register frees up, and the
//   input stays not ready meanwhile.
//   Reset returns the registers to their defaults (key zero, four key words,
//   44 rounds, z sequence 3) and drops any block in progress.
// ----------------------------------------------------------------------------
module simon_block_encrypt_core
  import sbe_pkg::*;
#(
  parameter int WORD_BITS  = 32,
  parameter int MAX_ROUNDS = 72
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [FIELD_W-1:0]   cfg_data_i,
  // plaintext stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*FIELD_W-1:0] s_axis_tdata,   // plain_x [31:0], plain_y [63:32]
  // ciphertext stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*FIELD_W-1:0] m_axis_tdata    // cipher_x [31:0], cipher_y [63:32]
);

  localparam int BW = $clog2(WORD_BITS);
  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int ZW = $clog2(ZLEN);

  // configuration registers
  logic [KEY_WORDS-1:0][FIELD_W-1:0] key_q, key_d;
  logic [2:0]                        key_count_q, key_count_d;
  logic [6:0]                        round_count_q, round_count_d;
  logic [2:0]                        z_index_q, z_index_d;

  // control
  sbe_state_e    state_q, state_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic [RW-1:0] rounds_q, rounds_d;
  logic [ZW-1:0] zcnt_q, zcnt_d;
  logic [2:0]    zsel_q, zsel_d;
  logic [2:0]    m_q, m_d;
  logic          out_valid_q, out_valid_d;

  // payload
  logic [WORD_BITS-1:0]   x_q, x_d, y_q, y_d;
  logic [2*FIELD_W-1:0]   out_data_q, out_data_d;

  sbe_ks_ctrl_t  ks_ctrl;
  logic          key_bit;
  logic          x_bit;
  logic          in_acc;
  logic          out_free;
  logic          last_bit;
  logic [2:0]    m_in;
  logic [6:0]    t_clamp;
  logic [2:0]    z_in;
  logic [ZW-1:0] z_pos;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign last_bit      = (bit_q == BW'(WORD_BITS - 1));
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // configuration writes
  always_comb begin
    key_d         = key_q;
    key_count_d   = key_count_q;
    round_count_d = round_count_q;
    z_index_d     = z_index_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY0:        key_d[0]      = cfg_data_i;
        CFG_KEY1:        key_d[1]      = cfg_data_i;
        CFG_KEY2:        key_d[2]      = cfg_data_i;
        CFG_KEY3:        key_d[3]      = cfg_data_i;
        CFG_KEY_COUNT:   key_count_d   = cfg_data_i[2:0];
        CFG_ROUND_COUNT: round_count_d = cfg_data_i[6:0];
        CFG_Z_INDEX:     z_index_d     = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // clamp the settings as a block enters
  always_comb begin
    priority if (key_count_q < 3'd2) begin
      m_in = 3'd2;
    end else if (key_count_q > 3'd4) begin
      m_in = 3'd4;
    end else begin
      m_in = key_count_q;
    end
    t_clamp = (round_count_q > 7'(MAX_ROUNDS)) ? 7'(MAX_ROUNDS) : round_count_q;
    z_in    = (z_index_q > 3'd4) ? 3'd4 : z_index_q;
  end

  // key schedule control
  assign z_pos = ZW'(ZLEN - 1) - zcnt_q;

  always_comb begin
    ks_ctrl.load     = in_acc;
    ks_ctrl.step     = (state_q == ST_RUN);
    ks_ctrl.last_bit = last_bit;
    ks_ctrl.low_bit  = (bit_q < BW'(2));
    ks_ctrl.m        = m_q;
    ks_ctrl.z_bit    = (bit_q == '0) && Z_SEQ[zsel_q][z_pos];
  end

  sbe_keysched #(
    .WORD_BITS(WORD_BITS)
  ) u_keysched (
    .clk_i           (clk_i),
    .ctrl_i          (ks_ctrl),
    .key_words_i     (key_q),
    .round_key_bit_o (key_bit)
  );

  // bit j of the new x; x rotates so that bits j-1, j-2, j-8 sit at the top
  assign x_bit = y_q[0] ^ (x_q[WORD_BITS-1] & x_q[WORD_BITS-8]) ^ x_q[WORD_BITS-2]
               ^ key_bit;

  always_comb begin
    state_d     = state_q;
    bit_d       = bit_q;
    rnd_d       = rnd_q;
    rounds_d    = rounds_q;
    zcnt_d      = zcnt_q;
    zsel_d      = zsel_q;
    m_d         = m_q;
    x_d         = x_q;
    y_d         = y_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_d      = WORD_BITS'(s_axis_tdata[FIELD_W-1:0]);
          y_d      = WORD_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
          bit_d    = '0;
          rnd_d    = '0;
          zcnt_d   = '0;
          rounds_d = RW'(t_clamp);
          zsel_d   = z_in;
          m_d      = m_in;
          state_d  = (t_clamp == 7'd0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_bit) begin
          // swap: y collected the new x, x is back in place as the new y
          x_d    = {x_bit, y_q[WORD_BITS-1:1]};
          y_d    = {x_q[0], x_q[WORD_BITS-1:1]};
          bit_d  = '0;
          rnd_d  = RW'(rnd_q + 1'b1);
          zcnt_d = (zcnt_q == ZW'(ZLEN - 1)) ? '0 : ZW'(zcnt_q + 1'b1);
          if (RW'(rnd_q + 1'b1) == rounds_q) begin
            state_d = ST_DONE;
          end
        end else begin
          x_d   = {x_q[0], x_q[WORD_BITS-1:1]};
          y_d   = {x_bit, y_q[WORD_BITS-1:1]};
          bit_d = BW'(bit_q + 1'b1);
        end
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {FIELD_W'(y_q), FIELD_W'(x_q)};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q         <= '0;
      key_count_q   <= 3'd4;
      round_count_q <= 7'd44;
      z_index_q     <= 3'd3;
      state_q       <= ST_IDLE;
      bit_q         <= '0;
      rnd_q         <= '0;
      rounds_q      <= '0;
      zcnt_q        <= '0;
      zsel_q        <= '0;
      m_q           <= 3'd4;
      out_valid_q   <= 1'b0;
    end else begin
      key_q         <= key_d;
      key_count_q   <= key_count_d;
      round_count_q <= round_count_d;
      z_index_q     <= z_index_d;
      state_q       <= state_d;
      bit_q         <= bit_d;
      rnd_q         <= rnd_d;
      rounds_q      <= rounds_d;
      zcnt_q        <= zcnt_d;
      zsel_q        <= zsel_d;
      m_q           <= m_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    out_data_q <= out_data_d;
  end

endmodule
